// ===== rtl/cc20_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_pkg
// shared constants, command type and helper functions for the chacha20 block
// ----------------------------------------------------------------------------
package cc20_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned WORDS      = 16;
   localparam int unsigned IDX_W      = $clog2(WORDS);
   localparam int unsigned LANES      = 4;
   localparam int unsigned LANE_W     = $clog2(LANES);
   localparam int unsigned NUM_ROUNDS = 20;
   localparam int unsigned ROUND_W    = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;

   localparam int unsigned ROT_16 = 16;
   localparam int unsigned ROT_12 = 12;
   localparam int unsigned ROT_8  = 8;
   localparam int unsigned ROT_7  = 7;

   localparam logic [LANE_W-1:0] ROLE_A = 2'd0;
   localparam logic [LANE_W-1:0] ROLE_B = 2'd1;
   localparam logic [LANE_W-1:0] ROLE_C = 2'd2;
   localparam logic [LANE_W-1:0] ROLE_D = 2'd3;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);
   localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);

   typedef struct packed {
      logic             wr_en;
      logic             init;
      logic             step_en;
      logic             diag;
      logic             half;
      logic             emit_en;
      logic             emit_last;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   // row is the role, column is the lane shifted by the role on diagonal rounds
   function automatic logic [IDX_W-1:0] qr_index(input logic diag,
                                                 input logic [LANE_W-1:0] lane,
                                                 input logic [LANE_W-1:0] role);
      logic [LANE_W-1:0] col;
      col = diag ? (lane + role) : lane;
      return {role, col};
   endfunction

endpackage

// ===== rtl/chacha20_block_function.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_block_function
// chacha20 block function, one state word in and one keystream word out per
// transaction
// ----------------------------------------------------------------------------
// State words are taken one per cycle while busy is low; the word with
// req_in_last set is stored at the current position and starts the block.
// busy then stays high while the state is copied, each round runs as two
// halves on four parallel quarter-round units (two add-xor-rotate steps per
// cycle), and the keystream words are emitted. Results come one per cycle
// on rsp_strobe, word 0 first, the sixteenth marked by rsp_out_last, and
// must be taken as they appear since the receiver cannot stall.
// ----------------------------------------------------------------------------
module chacha20_block_function (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [cc20_pkg::WORD_W-1:0] req_in_word,
   input  logic                        req_in_last,
   output logic                        rsp_strobe,
   output logic [cc20_pkg::WORD_W-1:0] rsp_out_word,
   output logic                        rsp_out_last
);

   cc20_pkg::cmd_type cmd;

   cc20_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_in_last (req_in_last),
      .busy        (busy),
      .cmd         (cmd)
   );

   cc20_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_in_word  (req_in_word),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_word (rsp_out_word),
      .rsp_out_last (rsp_out_last)
   );

endmodule

// ===== rtl/cc20_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_ctrl
// sequencer: word load, state copy, round steps and keystream emission
// ----------------------------------------------------------------------------
module cc20_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_in_last,
   output logic              busy,
   output cc20_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_INIT,
      ST_ROUND,
      ST_EMIT
   } state_type;

   state_type                      state_ff, state_in;
   logic [cc20_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [cc20_pkg::ROUND_W-1:0]   round_ff, round_in;
   logic                           half_ff, half_in;
   logic                           busy_ff, busy_in;
   logic                           accept;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      round_in = round_ff;
      half_in  = half_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cmd.wr_en = 1'b1;
               if (req_in_last) begin
                  state_in = ST_INIT;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_ROUND;
            round_in = '0;
            half_in  = 1'b0;
         end
         ST_ROUND: begin
            cmd.step_en = 1'b1;
            cmd.diag    = round_ff[0];
            cmd.half    = half_ff;
            half_in     = !half_ff;
            if (half_ff) begin
               if (round_ff == cc20_pkg::LAST_ROUND) begin
                  state_in = ST_EMIT;
                  idx_in   = '0;
               end else begin
                  round_in = round_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            cmd.emit_en   = 1'b1;
            cmd.emit_last = (idx_ff == cc20_pkg::LAST_IDX);
            idx_in        = idx_ff + 1'b1;
            if (idx_ff == cc20_pkg::LAST_IDX) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      busy_in = (state_in != ST_LOAD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         idx_ff   <= '0;
         round_ff <= '0;
         half_ff  <= 1'b0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         round_ff <= round_in;
         half_ff  <= half_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

// ===== rtl/cc20_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_dp
// datapath: input word store, working state with four quarter-round units,
// final add and result register
// ----------------------------------------------------------------------------
module cc20_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  cc20_pkg::cmd_type           cmd,
   input  logic [cc20_pkg::WORD_W-1:0] req_in_word,
   output logic                        rsp_strobe,
   output logic [cc20_pkg::WORD_W-1:0] rsp_out_word,
   output logic                        rsp_out_last
);

   logic [cc20_pkg::WORD_W-1:0] in_words_ff [cc20_pkg::WORDS];
   logic [cc20_pkg::WORD_W-1:0] work_ff     [cc20_pkg::WORDS];
   logic [cc20_pkg::WORD_W-1:0] work_in     [cc20_pkg::WORDS];
   logic [cc20_pkg::WORD_W-1:0] word_ff, word_in;
   logic                        last_ff;
   logic                        strobe_ff;

   // half 0: rotations 16 and 12, half 1: rotations 8 and 7
   always_comb begin
      logic [cc20_pkg::WORD_W-1:0] a, b, c, d, x, y;
      logic [cc20_pkg::IDX_W-1:0]  ia, ib, ic, id;
      a  = '0;
      b  = '0;
      c  = '0;
      d  = '0;
      x  = '0;
      y  = '0;
      ia = '0;
      ib = '0;
      ic = '0;
      id = '0;
      work_in = work_ff;
      if (cmd.init) begin
         work_in = in_words_ff;
      end else if (cmd.step_en) begin
         for (int lane = 0; lane < cc20_pkg::LANES; lane++) begin
            ia = cc20_pkg::qr_index(cmd.diag, cc20_pkg::LANE_W'(lane), cc20_pkg::ROLE_A);
            ib = cc20_pkg::qr_index(cmd.diag, cc20_pkg::LANE_W'(lane), cc20_pkg::ROLE_B);
            ic = cc20_pkg::qr_index(cmd.diag, cc20_pkg::LANE_W'(lane), cc20_pkg::ROLE_C);
            id = cc20_pkg::qr_index(cmd.diag, cc20_pkg::LANE_W'(lane), cc20_pkg::ROLE_D);
            a  = work_ff[ia] + work_ff[ib];
            x  = work_ff[id] ^ a;
            d  = cmd.half ? cc20_pkg::rotl(x, cc20_pkg::ROT_8)
                          : cc20_pkg::rotl(x, cc20_pkg::ROT_16);
            c  = work_ff[ic] + d;
            y  = work_ff[ib] ^ c;
            b  = cmd.half ? cc20_pkg::rotl(y, cc20_pkg::ROT_7)
                          : cc20_pkg::rotl(y, cc20_pkg::ROT_12);
            work_in[ia] = a;
            work_in[ib] = b;
            work_in[ic] = c;
            work_in[id] = d;
         end
      end
   end

   assign word_in = work_ff[cmd.idx] + in_words_ff[cmd.idx];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         in_words_ff[cmd.idx] <= req_in_word;
      end
      work_ff <= work_in;
      if (cmd.emit_en) begin
         word_ff <= word_in;
         last_ff <= cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit_en;
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_out_word = word_ff;
   assign rsp_out_last = last_ff;

endmodule

// ===== rtl/cc20_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_chk
// port-level checks of the chacha20 block transaction sequencing
// ----------------------------------------------------------------------------
module cc20_chk (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_in_last,
   input logic rsp_strobe,
   input logic rsp_out_last
);

   // flagged word starts the block
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_in_last |=> busy)
      else $error("flagged word did not raise busy");

   // results of a block come back to back
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_out_last |=> rsp_strobe)
      else $error("gap inside keystream burst");

   // nothing follows the last word
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_out_last |=> !rsp_strobe)
      else $error("transaction after last keystream word");

   // block is finished when the last word shows
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_out_last |-> !busy)
      else $error("busy still high on last keystream word");

   // results other than the last word only come while a block is running
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_out_last |-> busy)
      else $error("keystream word outside a block");

endmodule

bind chacha20_block_function cc20_chk u_cc20_chk (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_in_last  (req_in_last),
   .rsp_strobe   (rsp_strobe),
   .rsp_out_last (rsp_out_last)
);

// ===== tb/sv/chacha20_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_checker
// watches the word and keystream channels of the chacha20 block, predicts
// every keystream word from the loaded state words and compares each
// received transaction against the oldest predicted word
// ----------------------------------------------------------------------------
module chacha20_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [cc20_pkg::WORD_W-1:0] req_in_word,
   input  logic                        req_in_last,
   input  logic                        rsp_strobe,
   input  logic [cc20_pkg::WORD_W-1:0] rsp_out_word,
   input  logic                        rsp_out_last,
   output int                          mismatch_count,
   output int                          pending_words
);

   typedef struct packed {
      logic [cc20_pkg::WORD_W-1:0] word;
      logic                        last;
   } keystream_word_type;

   logic [cc20_pkg::WORD_W-1:0] state_words [cc20_pkg::WORDS];
   logic [cc20_pkg::WORD_W-1:0] mix_words [cc20_pkg::WORDS];
   logic [cc20_pkg::IDX_W-1:0]  load_pos;
   keystream_word_type          keystream_q [$];
   int                          error_total;

   function automatic logic [cc20_pkg::WORD_W-1:0] rotate_left(
      input logic [cc20_pkg::WORD_W-1:0] v,
      input int n);
      return (v << n) | (v >> (cc20_pkg::WORD_W - n));
   endfunction

   task automatic quarter_round(input int a, input int b, input int c, input int d);
      mix_words[a] = mix_words[a] + mix_words[b];
      mix_words[d] = rotate_left(mix_words[d] ^ mix_words[a], 16);
      mix_words[c] = mix_words[c] + mix_words[d];
      mix_words[b] = rotate_left(mix_words[b] ^ mix_words[c], 12);
      mix_words[a] = mix_words[a] + mix_words[b];
      mix_words[d] = rotate_left(mix_words[d] ^ mix_words[a], 8);
      mix_words[c] = mix_words[c] + mix_words[d];
      mix_words[b] = rotate_left(mix_words[b] ^ mix_words[c], 7);
   endtask

   task automatic compute_keystream();
      keystream_word_type item;
      for (int k = 0; k < cc20_pkg::WORDS; k++) mix_words[k] = state_words[k];
      for (int r = 0; r < cc20_pkg::NUM_ROUNDS; r++) begin
         if (r % 2 == 0) begin
            quarter_round(0, 4, 8, 12);
            quarter_round(1, 5, 9, 13);
            quarter_round(2, 6, 10, 14);
            quarter_round(3, 7, 11, 15);
         end else begin
            quarter_round(0, 5, 10, 15);
            quarter_round(1, 6, 11, 12);
            quarter_round(2, 7, 8, 13);
            quarter_round(3, 4, 9, 14);
         end
      end
      for (int k = 0; k < cc20_pkg::WORDS; k++) begin
         item.word = mix_words[k] + state_words[k];
         item.last = (k == cc20_pkg::WORDS - 1);
         keystream_q.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      keystream_word_type exp_word;
      if (reset) begin
         load_pos = '0;
      end else begin
         if (rsp_strobe) begin
            if (keystream_q.size() == 0) begin
               error_total++;
               $display("%0t: unexpected keystream transaction word=%h last=%b",
                        $time, rsp_out_word, rsp_out_last);
            end else begin
               exp_word = keystream_q.pop_front();
               if (rsp_out_word !== exp_word.word) begin
                  error_total++;
                  $display("%0t: out_word mismatch expected=%h actual=%h",
                           $time, exp_word.word, rsp_out_word);
               end
               if (rsp_out_last !== exp_word.last) begin
                  error_total++;
                  $display("%0t: out_last mismatch expected=%b actual=%b",
                           $time, exp_word.last, rsp_out_last);
               end
            end
         end
         if (start && !busy) begin
            state_words[load_pos] = req_in_word;
            if (req_in_last) begin
               compute_keystream();
               load_pos = '0;
            end else begin
               load_pos = load_pos + 1'b1;
            end
         end
      end
      pending_words  <= keystream_q.size();
      mismatch_count <= error_total;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives state words into the chacha20 block: a few directed blocks with
// extreme words and early flags, then random full blocks, early-flagged
// blocks and wrapping unflagged runs under changing sender idle rates
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_ITEMS = 200;
   localparam int CYCLE_LIMIT  = 200000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [cc20_pkg::WORD_W-1:0]   req_in_word = '0;
   logic                          req_in_last = 1'b0;
   logic                          rsp_strobe;
   logic [cc20_pkg::WORD_W-1:0]   rsp_out_word;
   logic                          rsp_out_last;
   int                            mismatch_count;
   int                            pending_words;

   logic [cc20_pkg::IDX_W-1:0]    load_pos = '0;
   int                            items_sent = 0;
   int                            idle_pct = 0;
   int                            cycle_count = 0;

   chacha20_block_function i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_in_word  (req_in_word),
      .req_in_last  (req_in_last),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_word (rsp_out_word),
      .rsp_out_last (rsp_out_last)
   );

   chacha20_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_in_word    (req_in_word),
      .req_in_last    (req_in_last),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_word   (rsp_out_word),
      .rsp_out_last   (rsp_out_last),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [cc20_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_state_word(input logic [cc20_pkg::WORD_W-1:0] w, input logic last);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_in_word <= w;
      req_in_last <= last;
      do @(posedge clock); while (busy);
      load_pos = last ? '0 : load_pos + 1'b1;
      items_sent++;
   endtask

   task automatic send_up_to(input logic [cc20_pkg::IDX_W-1:0] flag_pos);
      while (load_pos != flag_pos) send_state_word(pick_word(), 1'b0);
      send_state_word(pick_word(), 1'b1);
   endtask

   initial begin
      int directed_items;
      int phase;
      int kind;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // all-ones block fills every state word
      for (int k = 0; k < cc20_pkg::WORDS; k++) begin
         send_state_word('1, k == cc20_pkg::WORDS - 1);
      end
      // early flag at the first position
      send_state_word('0, 1'b1);
      // early flag partway, older words still in place
      send_state_word(32'h8000_0000, 1'b0);
      send_state_word(32'h0000_0001, 1'b0);
      send_state_word(32'h5555_aaaa, 1'b0);
      send_state_word(32'haaaa_5555, 1'b1);
      directed_items = items_sent;

      while (items_sent < directed_items + RANDOM_ITEMS) begin
         phase = (items_sent - directed_items) * 4 / RANDOM_ITEMS;
         case (phase)
            0: idle_pct = 0;
            1: idle_pct = 64;
            2: idle_pct = 0;
            default: idle_pct = 26;
         endcase
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            send_up_to(cc20_pkg::LAST_IDX);
         end else if (kind < 85) begin
            if (load_pos == cc20_pkg::LAST_IDX) send_state_word(pick_word(), 1'b0);
            send_up_to(cc20_pkg::IDX_W'($urandom_range(load_pos, cc20_pkg::WORDS - 2)));
         end else begin
            // unflagged run, can wrap past the last position
            repeat ($urandom_range(1, 20)) send_state_word(pick_word(), 1'b0);
         end
      end
      start <= 1'b0;

      do @(posedge clock); while (pending_words != 0);
      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && pending_words == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
